[hdl/shp_pkg.sv]
package shp_pkg;

  localparam int TEXT_CAP    = 64;
  localparam int MAX_HEADERS = 32;
  localparam int NKNOWN      = 12;
  localparam int RES_MAX     = 4;

  // position counters saturate just above anything a compare can see
  localparam int POS_W = $clog2(TEXT_CAP) + 1;
  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(TEXT_CAP - 1);
  localparam logic [5:0]       HDR_LIMIT = 6'(MAX_HEADERS);

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PARTIAL   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  field_id;
    logic [5:0]  char_index;
    logic [7:0]  char_value;
    logic [5:0]  value_length;
    logic        value_clipped;
    status_t     parse_status;
    logic        any_truncated;
    logic        header_limit_hit;
    logic [5:0]  headers_seen;
    logic        run_last;
  } res_t;

  typedef res_t [RES_MAX-1:0] res_vec_t;

  typedef struct packed {
    res_vec_t   res;
    logic [2:0] count;
  } res_bundle_t;

endpackage

[hdl/shp_core.sv]
module shp_core import shp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  message_byte,
  input  logic        last_byte,
  output res_bundle_t bundle
);

  typedef struct packed {
    logic              on_start;
    logic [5:0]        hdr_cnt;
    logic              in_name;
    logic [4:0]        name_len;
    logic [NKNOWN-1:0] cand;
    logic [3:0]        cur_field;
    logic              skip_ws;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  trim_len;
    logic              pend_cr;
    logic              has_content;
    logic              trunc_seen;
    logic              finished;
  } pstate_t;

  localparam pstate_t PSTATE_RESET = '{
    on_start: 1'b1, hdr_cnt: '0, in_name: 1'b1, name_len: '0, cand: '1,
    cur_field: '0, skip_ws: 1'b1, pos: '0, trim_len: '0, pend_cr: 1'b0,
    has_content: 1'b0, trunc_seen: 1'b0, finished: 1'b0};

  localparam logic [4:0] KNOWN_LEN [NKNOWN] =
    '{5'd2, 5'd2, 5'd3, 5'd6, 5'd8, 5'd3, 5'd2, 5'd10, 5'd12, 5'd15, 5'd9, 5'd11};

  function automatic logic [7:0] known_char(input int k, input logic [3:0] p);
    logic [127:0] s;
    logic [3:0]   bi;
    begin
      case (k)
        0:       s = 128'("st");
        1:       s = 128'("nt");
        2:       s = 128'("usn");
        3:       s = 128'("server");
        4:       s = 128'("location");
        5:       s = 128'("man");
        6:       s = 128'("mx");
        7:       s = 128'("devicetype");
        8:       s = 128'("manufacturer");
        9:       s = 128'("manufacturerurl");
        10:      s = 128'("modelname");
        default: s = 128'("modelnumber");
      endcase
      bi = 4'(KNOWN_LEN[k] - 5'd1) - p;
      known_char = s[{bi, 3'b000} +: 8];
    end
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic void emit(inout res_bundle_t o, input res_t r);
    begin
      if (o.count < 3'(RES_MAX)) begin
        o.res[o.count[1:0]] = r;
        o.count = o.count + 3'd1;
      end
    end
  endfunction

  function automatic void status(inout pstate_t s, inout res_bundle_t o,
                                 input status_t st, input logic lim);
    res_t r;
    begin
      r = '0;
      r.kind = KIND_STATUS;
      r.parse_status = st;
      r.any_truncated = s.trunc_seen;
      r.header_limit_hit = lim;
      r.headers_seen = s.hdr_cnt;
      emit(o, r);
      s.finished = 1'b1;
    end
  endfunction

  function automatic void new_line(inout pstate_t s);
    begin
      s.in_name = 1'b1; s.name_len = '0; s.cand = '1; s.cur_field = '0;
      s.skip_ws = 1'b1; s.pos = '0; s.trim_len = '0; s.has_content = 1'b0;
    end
  endfunction

  function automatic void value_byte(inout pstate_t s, inout res_bundle_t o,
                                     input logic [7:0] b, input logic [3:0] fid);
    res_t r;
    begin
      r = '0;
      if (!(s.skip_ws && is_ws(b))) begin
        s.skip_ws = 1'b0;
        if (s.pos < POS_LIMIT) begin
          r.kind = KIND_BYTE;
          r.field_id = fid;
          r.char_index = s.pos[5:0];
          r.char_value = b;
          emit(o, r);
        end
        if (s.pos != POS_MAX) s.pos = s.pos + 1'b1;
        if (!is_ws(b) && b != CH_CR) s.trim_len = s.pos;
      end
    end
  endfunction

  function automatic void content(inout pstate_t s, inout res_bundle_t o,
                                  input logic [7:0] b);
    logic [7:0] lower;
    logic       done;
    logic       found;
    begin
      done = 1'b0;
      found = 1'b0;
      lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
      if (s.finished) begin
        done = 1'b1;
      end else if (s.on_start) begin
        s.has_content = 1'b1;
        value_byte(s, o, b, 4'd0);
        done = 1'b1;
      end
      if (!done && !s.has_content) begin
        s.has_content = 1'b1;
        if (s.hdr_cnt >= HDR_LIMIT) begin
          status(s, o, ST_PARTIAL, 1'b1);
          done = 1'b1;
        end else begin
          s.hdr_cnt = s.hdr_cnt + 6'd1;
        end
      end
      if (!done && s.in_name) begin
        if (b == CH_COLON) begin
          if (s.name_len == '0) begin
            status(s, o, ST_MALFORMED, 1'b0);
          end else begin
            s.cur_field = '0;
            for (int k = 0; k < NKNOWN; k++) begin
              if (!found && s.cand[k] && KNOWN_LEN[k] == s.name_len) begin
                s.cur_field = 4'(k + 1);
                found = 1'b1;
              end
            end
            s.in_name = 1'b0;
            s.skip_ws = 1'b1; s.pos = '0; s.trim_len = '0;
          end
        end else begin
          for (int k = 0; k < NKNOWN; k++) begin
            if (!(s.name_len < KNOWN_LEN[k] &&
                  known_char(k, s.name_len[3:0]) == lower))
              s.cand[k] = 1'b0;
          end
          if (s.name_len != 5'd31) s.name_len = s.name_len + 5'd1;
        end
      end else if (!done && s.cur_field != '0) begin
        value_byte(s, o, b, s.cur_field);
      end
    end
  endfunction

  function automatic void emit_length(inout pstate_t s, inout res_bundle_t o,
                                      input logic [3:0] fid);
    res_t r;
    logic clip;
    begin
      r = '0;
      clip = s.trim_len > POS_LIMIT;
      if (clip) s.trunc_seen = 1'b1;
      r.kind = KIND_LENGTH;
      r.field_id = fid;
      r.value_length = clip ? POS_LIMIT[5:0] : s.trim_len[5:0];
      r.value_clipped = clip;
      emit(o, r);
    end
  endfunction

  function automatic void line_end(inout pstate_t s, inout res_bundle_t o);
    begin
      if (!s.finished) begin
        if (s.on_start) begin
          emit_length(s, o, 4'd0);
          if (s.trim_len == '0) status(s, o, ST_MALFORMED, 1'b0);
          s.on_start = 1'b0;
        end else if (!s.has_content) begin
          status(s, o, s.trunc_seen ? ST_PARTIAL : ST_OK, 1'b0);
        end else if (s.in_name) begin
          status(s, o, ST_MALFORMED, 1'b0);
        end else if (s.cur_field != '0) begin
          emit_length(s, o, s.cur_field);
        end
        new_line(s);
      end
    end
  endfunction

  pstate_t st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    bundle = '0;
    if (st_r.finished) begin
      if (last_byte) st_nxt = PSTATE_RESET;
    end else begin
      if (message_byte == CH_LF) begin
        st_nxt.pend_cr = 1'b0;
        line_end(st_nxt, bundle);
      end else if (message_byte == CH_CR) begin
        if (st_nxt.pend_cr) content(st_nxt, bundle, CH_CR);
        st_nxt.pend_cr = 1'b1;
        if (last_byte) begin
          st_nxt.pend_cr = 1'b0;
          line_end(st_nxt, bundle);
        end
      end else begin
        if (st_nxt.pend_cr) begin
          st_nxt.pend_cr = 1'b0;
          content(st_nxt, bundle, CH_CR);
        end
        content(st_nxt, bundle, message_byte);
        if (last_byte) line_end(st_nxt, bundle);
      end
      if (last_byte) begin
        if (!st_nxt.finished)
          status(st_nxt, bundle, st_nxt.trunc_seen ? ST_PARTIAL : ST_OK, 1'b0);
        st_nxt = PSTATE_RESET;
      end
      if (bundle.count != '0)
        bundle.res[2'(bundle.count - 3'd1)].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PSTATE_RESET;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

endmodule

[hdl/shp_out_buf.sv]
module shp_out_buf import shp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  res_bundle_t bundle,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  res_vec_t   res_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == '0) || (cnt_r == 3'd1 && out_ready);
  assign out_res   = res_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= bundle.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= bundle.res;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) res_r[i] <= res_r[i+1];
    end
  end

endmodule

[hdl/ssdp_header_parser.sv]
// SSDP header parser.
// Input channel: one message byte per request (in_message_byte), with
// in_last_byte marking the final byte. Output channel: result requests of
// three kinds (value byte, value length, message status); run_last marks the
// final result caused by one input byte.
// Each accepted byte is parsed in the cycle it is accepted; its results
// (zero to four) sit in a result buffer and appear on out_* from the next
// cycle, one per cycle while out_ready is high.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_ready is high; a byte yielding more holds in_ready low until the
// single-port drain of the result buffer is down to the result being taken.
// When the receiver stalls, the buffer holds and in_ready drops while it
// holds any result.
// Reset (rst_n low, synchronous) empties the buffer and returns the parser to
// the start of a message; after last_byte it returns there on its own.
module ssdp_header_parser import shp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_message_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [3:0]  out_field_id,
  output logic [5:0]  out_char_index,
  output logic [7:0]  out_char_value,
  output logic [5:0]  out_value_length,
  output logic        out_value_clipped,
  output logic [1:0]  out_parse_status,
  output logic        out_any_truncated,
  output logic        out_header_limit_hit,
  output logic [5:0]  out_headers_seen,
  output logic        out_run_last
);

  res_bundle_t bundle;
  res_t        res;
  logic        take;

  assign take = in_valid && in_ready;

  shp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .message_byte (in_message_byte),
    .last_byte    (in_last_byte),
    .bundle       (bundle)
  );

  shp_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .bundle    (bundle),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_result_kind      = res.kind;
  assign out_field_id         = res.field_id;
  assign out_char_index       = res.char_index;
  assign out_char_value       = res.char_value;
  assign out_value_length     = res.value_length;
  assign out_value_clipped    = res.value_clipped;
  assign out_parse_status     = res.parse_status;
  assign out_any_truncated    = res.any_truncated;
  assign out_header_limit_hit = res.header_limit_hit;
  assign out_headers_seen     = res.headers_seen;
  assign out_run_last         = res.run_last;

endmodule

[hdl/shp_checker.sv]
module shp_checker import shp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_result_kind,
  input logic [3:0] out_field_id,
  input logic [7:0] out_char_value,
  input logic [5:0] out_value_length,
  input logic       out_value_clipped
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_status_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STATUS |-> out_field_id == 4'd0 &&
    out_char_value == 8'd0)
    else $error("status request carries field data");

  a_clip_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_LENGTH && out_value_clipped |->
    out_value_length == 6'(TEXT_CAP - 1))
    else $error("clipped length not at cap");

endmodule

bind ssdp_header_parser shp_checker u_shp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_result_kind   (out_result_kind),
  .out_field_id      (out_field_id),
  .out_char_value    (out_char_value),
  .out_value_length  (out_value_length),
  .out_value_clipped (out_value_clipped)
);
